/* src/mwps_pkg.sv */
// Shared types, constants and a helper function of the masked word pattern scanner.
package mwps_pkg;

    localparam int MAX_PATTERN_WORDS = 16;
    localparam int OFFSET_BITS       = 22;
    localparam int IDX_BITS          = $clog2(MAX_PATTERN_WORDS);
    localparam int LEN_BITS          = $clog2(MAX_PATTERN_WORDS + 1);
    localparam int WORD_BITS         = 32;
    localparam int ENTRY_BITS        = 4;
    localparam int CFG_IDX_BITS      = 2;

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

    // Request opcodes.
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_SCAN    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCAN_BASE      = 2'd1;

    typedef struct packed {
        logic [1:0]            opcode;
        logic [ENTRY_BITS-1:0] entry_index;
        logic [WORD_BITS-1:0]  pattern_word;
        logic [WORD_BITS-1:0]  mask_word;
        logic [WORD_BITS-1:0]  data_word;
        logic                  last_word;
    } req_t;

    typedef struct packed {
        logic                   found;
        logic [WORD_BITS-1:0]   match_address;
        logic [OFFSET_BITS-1:0] match_offset;
    } res_t;

    // Per-cell control: shift enable and the cell's role for the current length.
    typedef struct packed {
        logic shift;
        logic in_use;
        logic start;
    } cell_ctrl_t;

    function automatic logic [WORD_BITS-1:0] swap_bytes(input logic [WORD_BITS-1:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

/* src/mwps_if.sv */
// Handshake interfaces of the scanner: request, result and configuration channels.
interface mwps_req_if;
    logic          valid;
    logic          ready;
    mwps_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mwps_res_if;
    logic          valid;
    logic          ready;
    mwps_pkg::res_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mwps_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [mwps_pkg::CFG_IDX_BITS-1:0]   index;
    logic [mwps_pkg::WORD_BITS-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/mwps_cell.sv */
// One window cell: holds a data word, passes it on, and compares it with its pattern entry.
module mwps_cell (
    input  logic                               clk,
    input  mwps_pkg::cell_ctrl_t               ctrl,
    input  logic [mwps_pkg::WORD_BITS-1:0]     word_in,
    input  logic [mwps_pkg::WORD_BITS-1:0]     pattern,
    input  logic [mwps_pkg::WORD_BITS-1:0]     mask,
    input  logic [mwps_pkg::WORD_BITS-1:0]     first_pattern,
    output logic [mwps_pkg::WORD_BITS-1:0]     word_out,
    output logic                               hit
);

    logic [mwps_pkg::WORD_BITS-1:0] word_reg;
    logic [mwps_pkg::WORD_BITS-1:0] word_next;
    logic                           masked_eq;
    logic                           exact_eq;

    // The compare looks at the word the cell is about to take in.
    assign masked_eq = (((word_in ^ pattern) & mask) == '0);
    assign exact_eq  = (word_in == first_pattern);
    assign hit       = !ctrl.in_use || (masked_eq && (!ctrl.start || exact_eq));

    always_comb
    begin
        word_next = ctrl.shift ? word_in : word_reg;
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word_out = word_reg;

endmodule

/* src/mwps_out_queue.sv */
// Two-entry result buffer between the compare logic and the result channel.
module mwps_out_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mwps_pkg::res_t push_data,
    output logic           can_push,
    output logic           out_valid,
    input  logic           out_ready,
    output mwps_pkg::res_t out_data
);

    logic [1:0]     cnt_reg;
    logic [1:0]     cnt_next;
    logic [1:0]     left;
    logic           pop;
    mwps_pkg::res_t head_reg;
    mwps_pkg::res_t head_next;
    mwps_pkg::res_t tail_reg;
    mwps_pkg::res_t tail_next;

    assign pop       = (cnt_reg != 2'd0) && out_ready;
    assign can_push  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = head_reg;

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        left      = cnt_reg - {1'b0, pop};
        if (pop)
        begin
            head_next = tail_reg;
        end
        if (push)
        begin
            if (left == 2'd0)
            begin
                head_next = push_data;
            end
            else
            begin
                tail_next = push_data;
            end
        end
        cnt_next = left + {1'b0, push};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

/* src/masked_word_pattern_scanner.sv */
// Top level of the masked word pattern scanner: control, pattern tables and window cell chain.
//
// Usage. Requests arrive on req: opcode 0 loads pattern entry entry_index (the pattern word is
// byte-swapped on the way in, the mask is stored as is), opcode 1 scans one data word, opcode
// 2 restarts the scan. Configuration writes on cfg set pattern_length (index 0) and scan_base
// (index 1); cfg is always ready, and the user writes it only while no scan is in flight;
// the block does not check it. A scan request yields at most one result on res: found with
// its address and word offset at the first matching start, or not-found when the word marked
// last_word ends a region without a match. A word marked last_word always closes the region.
//
// Timing. The window shifts and all cells compare in the cycle of acceptance, and the result
// is registered in the two-entry buffer before it shows on res. One request per cycle is taken
// while the buffer has room.
//
// Reset. rst_n clears the word count and the match flag, sets pattern_length to 1 and
// scan_base to 0. The window cells and the pattern and mask tables are not reset; a compare
// only ever looks at words of the current region and at loaded entries.
//
// Stalls. Results go into a two-entry buffer; req.ready falls only when both entries wait
// on a stalled receiver, so a held-up result never blocks the following request by itself.
module masked_word_pattern_scanner (
    input  logic          clk,
    input  logic          rst_n,
    mwps_cfg_if.sink      cfg,
    mwps_req_if.sink      req,
    mwps_res_if.source    res
);

    localparam int NW = mwps_pkg::MAX_PATTERN_WORDS;
    localparam int LB = mwps_pkg::LEN_BITS;
    localparam int IB = mwps_pkg::IDX_BITS;
    localparam int OB = mwps_pkg::OFFSET_BITS;
    localparam int WB = mwps_pkg::WORD_BITS;

    // Configuration registers.
    logic [LB-1:0] pattern_length_reg;
    logic [WB-1:0] scan_base_reg;

    // Pattern and mask tables, indexed by pattern position.
    logic [WB-1:0] pattern_reg [NW];
    logic [WB-1:0] mask_reg    [NW];

    // Scan state.
    logic [OB-1:0] count_reg;
    logic [OB-1:0] count_next;
    logic          matched_reg;
    logic          matched_next;

    logic          accept;
    logic          is_load;
    logic          is_scan;
    logic          is_restart;
    logic          scan_go;
    logic          last_w;
    logic [LB-1:0] used_len;
    logic [OB-1:0] count_inc;
    logic [OB-1:0] match_off;
    logic [WB-1:0] match_addr;
    logic          all_hit;
    logic          match_w;
    logic          push;
    logic          can_push;
    mwps_pkg::res_t push_data;

    logic [WB-1:0] cell_word [NW];
    logic [NW-1:0] cell_hit;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= LB'(1);
            scan_base_reg      <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                mwps_pkg::CFG_PATTERN_LENGTH: pattern_length_reg <= cfg.data[LB-1:0];
                mwps_pkg::CFG_SCAN_BASE:      scan_base_reg      <= cfg.data;
                default: ;
            endcase
        end
    end

    // A length of zero acts as one, anything past the table size as the table size.
    always_comb
    begin
        if (pattern_length_reg == '0)
        begin
            used_len = LB'(1);
        end
        else if (pattern_length_reg > LB'(NW))
        begin
            used_len = LB'(NW);
        end
        else
        begin
            used_len = pattern_length_reg;
        end
    end

    assign req.ready  = can_push;
    assign accept     = req.valid && req.ready;
    assign is_load    = accept && (req.data.opcode == mwps_pkg::OP_LOAD);
    assign is_scan    = accept && (req.data.opcode == mwps_pkg::OP_SCAN);
    assign is_restart = accept && (req.data.opcode == mwps_pkg::OP_RESTART);
    assign last_w     = req.data.last_word;

    // Words are compared only until the first match and while the count has room.
    assign scan_go    = is_scan && !matched_reg && (count_reg != mwps_pkg::OFFSET_MAX);
    assign count_inc  = count_reg + OB'(1);
    assign match_off  = count_inc - OB'(used_len);
    assign match_addr = scan_base_reg + WB'({match_off, 2'b00});
    assign all_hit    = &cell_hit;
    assign match_w    = scan_go && (count_inc >= OB'(used_len)) && all_hit;

    // Pattern loads. Entry indexes past the table are dropped.
    always_ff @(posedge clk)
    begin
        if (is_load && (int'(req.data.entry_index) < NW))
        begin
            pattern_reg[req.data.entry_index[IB-1:0]] <=
                mwps_pkg::swap_bytes(req.data.pattern_word);
            mask_reg[req.data.entry_index[IB-1:0]] <= req.data.mask_word;
        end
    end

    // Window cells. Cell 0 holds the newest word; cell k lines up with pattern entry
    // used_len-1-k, and cell used_len-1 holds the start word of the candidate.
    for (genvar k = 0; k < NW; k++)
    begin : g_cell
        logic [WB-1:0]        word_in;
        logic [LB-1:0]        sel_full;
        mwps_pkg::cell_ctrl_t ctrl;

        assign sel_full    = used_len - LB'(1) - LB'(k);
        assign ctrl.shift  = scan_go;
        assign ctrl.in_use = (LB'(k) < used_len);
        assign ctrl.start  = (LB'(k) == (used_len - LB'(1)));

        if (k == 0)
        begin : g_head
            assign word_in = req.data.data_word;
        end
        else
        begin : g_body
            assign word_in = cell_word[k-1];
        end

        mwps_cell u_cell (
            .clk           (clk),
            .ctrl          (ctrl),
            .word_in       (word_in),
            .pattern       (pattern_reg[sel_full[IB-1:0]]),
            .mask          (mask_reg[sel_full[IB-1:0]]),
            .first_pattern (pattern_reg[0]),
            .word_out      (cell_word[k]),
            .hit           (cell_hit[k])
        );
    end

    // Scan state update. A restart or the end of a region clears the count and the flag.
    always_comb
    begin
        count_next   = count_reg;
        matched_next = matched_reg;
        if (is_restart || (is_scan && last_w))
        begin
            count_next   = '0;
            matched_next = 1'b0;
        end
        else if (scan_go)
        begin
            count_next = count_inc;
            if (match_w)
            begin
                matched_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            matched_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            matched_reg <= matched_next;
        end
    end

    // A match reports at once; a region that ends without one reports not-found.
    assign push = match_w || (is_scan && last_w && !matched_reg);

    always_comb
    begin
        push_data = '0;
        if (match_w)
        begin
            push_data.found         = 1'b1;
            push_data.match_address = match_addr;
            push_data.match_offset  = match_off;
        end
    end

    mwps_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .can_push  (can_push),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .out_data  (res.data)
    );

`ifndef SYNTH
    // Once a match is taken, the region stays quiet until it ends.
    a_match_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (match_w && !last_w) |=> matched_reg)
        else $error("match flag not set after a match");

    a_no_second_match: assert property (@(posedge clk) disable iff (!rst_n)
        matched_reg |-> !match_w)
        else $error("second match in one region");

    a_count_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (scan_go && !last_w) |=> (count_reg == $past(count_inc)))
        else $error("word count did not advance on a compared word");
`endif

endmodule

/* verif/scan_result_checker.sv */
// Checker of the masked word pattern scanner: predicts every result from the requests and compares.
module scan_result_checker
    import mwps_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    mwps_cfg_if  cfg,
    mwps_req_if  req,
    mwps_res_if  res,
    output int   failures,
    output int   outstanding
);

    logic [WORD_BITS-1:0]   stored_pattern [MAX_PATTERN_WORDS];
    logic [WORD_BITS-1:0]   stored_mask    [MAX_PATTERN_WORDS];
    // Index 0 holds the newest scanned word.
    logic [WORD_BITS-1:0]   recent_words   [MAX_PATTERN_WORDS];
    logic [OFFSET_BITS-1:0] words_seen;
    logic                   match_seen;
    logic [4:0]             length_setting;
    logic [WORD_BITS-1:0]   base_setting;
    res_t                   awaited_results [$];

    initial
    begin
        failures    = 0;
        outstanding = 0;
    end

    task automatic note_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        failures++;
    endtask

    task automatic clear_scan();
        int j;
        for (j = 0; j < MAX_PATTERN_WORDS; j++)
            recent_words[j] = '0;
        words_seen = '0;
        match_seen = 1'b0;
    endtask

    function automatic int words_in_use();
        int n;
        n = length_setting;
        if (n == 0)
            n = 1;
        if (n > MAX_PATTERN_WORDS)
            n = MAX_PATTERN_WORDS;
        return n;
    endfunction

    // The start word sits n-1 places back; the first signature word must match exactly.
    function automatic bit signature_at_start(input int n);
        bit hit;
        int j;
        hit = (recent_words[n-1] == stored_pattern[0]);
        for (j = 0; j < n; j++)
            if ((recent_words[n-1-j] & stored_mask[j]) != (stored_pattern[j] & stored_mask[j]))
                hit = 1'b0;
        return hit;
    endfunction

    task automatic predict_request(input req_t item);
        int                     n;
        int                     k;
        logic [OFFSET_BITS-1:0] start;
        res_t                   outcome;
        case (item.opcode)
            OP_LOAD:
            begin
                stored_pattern[item.entry_index] = {item.pattern_word[7:0],
                    item.pattern_word[15:8], item.pattern_word[23:16], item.pattern_word[31:24]};
                stored_mask[item.entry_index] = item.mask_word;
            end
            OP_RESTART:
                clear_scan();
            OP_SCAN:
            begin
                if (!match_seen && words_seen != OFFSET_MAX)
                begin
                    n = words_in_use();
                    for (k = MAX_PATTERN_WORDS - 1; k > 0; k--)
                        recent_words[k] = recent_words[k-1];
                    recent_words[0] = item.data_word;
                    words_seen++;
                    if (words_seen >= n && signature_at_start(n))
                    begin
                        start                 = words_seen - OFFSET_BITS'(n);
                        outcome.found         = 1'b1;
                        outcome.match_address = base_setting + {start, 2'b00};
                        outcome.match_offset  = start;
                        awaited_results.push_back(outcome);
                        match_seen = 1'b1;
                    end
                end
                if (item.last_word)
                begin
                    if (!match_seen)
                    begin
                        outcome = '0;
                        awaited_results.push_back(outcome);
                    end
                    clear_scan();
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_result(input res_t got);
        res_t want;
        if (awaited_results.size() == 0)
        begin
            note_mismatch($sformatf("result with nothing awaited: found %b address %h offset %h",
                                    got.found, got.match_address, got.match_offset));
            return;
        end
        want = awaited_results.pop_front();
        if (got.found !== want.found)
            note_mismatch($sformatf("found %b, predicted %b", got.found, want.found));
        if (got.match_address !== want.match_address)
            note_mismatch($sformatf("match_address %h, predicted %h",
                                    got.match_address, want.match_address));
        if (got.match_offset !== want.match_offset)
            note_mismatch($sformatf("match_offset %h, predicted %h",
                                    got.match_offset, want.match_offset));
    endtask

    // Results are checked before the request of the same edge is predicted, since a
    // result can never belong to a request accepted at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_setting = 5'd1;
            base_setting   = '0;
            clear_scan();
            awaited_results.delete();
            outstanding = 0;
        end
        else
        begin
            if (res.valid && res.ready)
                check_result(res.data);
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_PATTERN_LENGTH)
                    length_setting = cfg.data[4:0];
                else if (cfg.index == CFG_SCAN_BASE)
                    base_setting = cfg.data;
            end
            if (req.valid && req.ready)
                predict_request(req.data);
            outstanding = awaited_results.size();
        end
    end

endmodule

/* verif/masked_word_pattern_scanner_test.sv */
// Testbench top of the masked word pattern scanner: clock, reset, stimulus and verdict.
module masked_word_pattern_scanner_test;
    import mwps_pkg::*;

    // The opcode that the block must ignore.
    localparam logic [1:0]              OP_IGNORED = 2'd3;
    // A configuration index with no register behind it.
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE  = 2'd3;

    // Number of counted requests, and the point from which nobody idles any more.
    localparam int REQUEST_TARGET = 1420;
    localparam int CALM_FROM      = 1250;

    // The slowest correct stretch without any handshake is a sender gap or a receiver
    // stall plus the short settling pauses; the limit is many times that.
    localparam int STALL_LIMIT = 500;

    logic clk = 1'b0;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   requests_sent = 0;
    int   quiet_cycles  = 0;

    // Chance of idling on either side, in steps; zero means no idling at all.
    int   idle_odds = 2;

    // The signature as the block holds it (after the byte swap), kept so that the
    // stimulus can plant matches and near misses in the scanned regions.
    logic [WORD_BITS-1:0] signature      [MAX_PATTERN_WORDS];
    logic [WORD_BITS-1:0] signature_mask [MAX_PATTERN_WORDS];

    mwps_req_if req_ch ();
    mwps_res_if res_ch ();
    mwps_cfg_if cfg_ch ();

    masked_word_pattern_scanner dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .res   (res_ch)
    );

    scan_result_checker checker_inst
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_ch),
        .req         (req_ch),
        .res         (res_ch),
        .failures    (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // A request with every field random; callers then set the fields that matter.
    function automatic req_t random_request(input logic [1:0] op);
        req_t item;
        item.opcode       = op;
        item.entry_index  = ENTRY_BITS'($urandom_range(0, MAX_PATTERN_WORDS - 1));
        item.pattern_word = $urandom;
        item.mask_word    = $urandom;
        item.data_word    = $urandom;
        item.last_word    = 1'($urandom_range(0, 1));
        return item;
    endfunction

    // Drives one request and returns right after the edge at which it is accepted.
    // Valid stays high afterwards so that back-to-back requests keep it up; it is only
    // lowered for a gap or when the phase settles.
    task automatic send_request(input req_t item);
        if (idle_odds != 0 && $urandom_range(0, 15) < idle_odds)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= item;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        if (item.opcode != OP_IGNORED)
            requests_sent++;
    endtask

    task automatic scan_word(input logic [WORD_BITS-1:0] word, input logic last);
        req_t item;
        item           = random_request(OP_SCAN);
        item.data_word = word;
        item.last_word = last;
        send_request(item);
    endtask

    // Loads one signature entry; the block swaps the bytes, so the stored word is sent
    // swapped and the local copy keeps it as the block will hold it.
    task automatic load_entry(input int entry, input logic [WORD_BITS-1:0] word,
                              input logic [WORD_BITS-1:0] mask);
        req_t item;
        item              = random_request(OP_LOAD);
        item.entry_index  = ENTRY_BITS'(entry);
        item.pattern_word = {word[7:0], word[15:8], word[23:16], word[31:24]};
        item.mask_word    = mask;
        signature[entry]      = word;
        signature_mask[entry] = mask;
        send_request(item);
    endtask

    task automatic restart_scan();
        send_request(random_request(OP_RESTART));
    endtask

    // Valid stays high on the configuration channel between back-to-back writes; the
    // caller lowers it once the last write of a group has gone through.
    task automatic put_register(input logic [CFG_IDX_BITS-1:0] index,
                                input logic [WORD_BITS-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
    endtask

    // Waits until every predicted result has come back, then gives the block a few
    // cycles more, since the last requests of a phase may cause no result at all.
    task automatic settle();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    // A fresh signature over all sixteen entries, with masks that are full, empty,
    // sparse or random, drawn anew for each entry.
    task automatic load_signature();
        int                   entry;
        logic [WORD_BITS-1:0] word;
        logic [WORD_BITS-1:0] mask;
        for (entry = 0; entry < MAX_PATTERN_WORDS; entry++)
        begin
            case ($urandom_range(0, 5))
                0:       word = '0;
                1:       word = '1;
                default: word = $urandom;
            endcase
            case ($urandom_range(0, 4))
                0:       mask = '1;
                1:       mask = '0;
                2:       mask = $urandom & $urandom;
                default: mask = $urandom;
            endcase
            load_entry(entry, word, mask);
        end
    endtask

    // One region of memory words. Most regions carry the signature at a random start,
    // often at the very last start that still fits, with the bits outside each mask
    // randomized; some get a flipped bit so that they become near misses. A few regions
    // are left open, and now and then a restart, a load or an ignored request cuts in.
    task automatic run_region(input int words_used);
        logic [WORD_BITS-1:0] region_words [64];
        int                   len;
        int                   at;
        int                   j;
        int                   spot;
        bit                   keep_open;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 64)
                                          : $urandom_range(1, words_used + 12);
        for (j = 0; j < len; j++)
            region_words[j] = $urandom;
        if (len >= words_used && $urandom_range(0, 4) != 0)
        begin
            at = ($urandom_range(0, 3) == 0) ? len - words_used
                                             : $urandom_range(0, len - words_used);
            for (j = 0; j < words_used; j++)
            begin
                if (j == 0)
                    region_words[at] = signature[0];
                else
                    region_words[at + j] = (signature[j] & signature_mask[j]) |
                                           ($urandom & ~signature_mask[j]);
            end
            if ($urandom_range(0, 3) == 0)
            begin
                spot = at + $urandom_range(0, words_used - 1);
                region_words[spot] = region_words[spot] ^ (32'h1 << $urandom_range(0, 31));
            end
        end
        keep_open = ($urandom_range(0, 19) == 0);
        for (j = 0; j < len; j++)
        begin
            case ($urandom_range(0, 29))
                0:       send_request(random_request(OP_IGNORED));
                1:       restart_scan();
                2:       load_entry($urandom_range(0, MAX_PATTERN_WORDS - 1), $urandom, $urandom);
                default: ;
            endcase
            scan_word(region_words[j], (j == len - 1) && !keep_open);
        end
    endtask

    // Receiver side: ready is dropped in bursts while idling is on.
    initial
    begin
        res_ch.ready <= 1'b1;
        forever
        begin
            repeat ($urandom_range(1, 40)) @(posedge clk);
            if (idle_odds != 0 && $urandom_range(0, 7) < idle_odds)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                res_ch.ready <= 1'b1;
            end
        end
    end

    // The watchdog counts cycles in which no channel moves anything.
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int                   length_choice;
        int                   words_used;
        int                   regions;
        logic [WORD_BITS-1:0] length_value;
        logic [WORD_BITS-1:0] base_value;
        bit                   first_phase;

        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. A three-word signature whose first word is all ones, the second
        // all zeros under a full mask and the third fully masked out; the base sits just
        // below the top of the address space so that the reported address wraps.
        put_register(CFG_PATTERN_LENGTH, 32'd3);
        put_register(CFG_SCAN_BASE, 32'hFFFF_FFFC);
        cfg_ch.valid <= 1'b0;
        load_entry(0, 32'hFFFF_FFFF, $urandom);
        load_entry(1, 32'h0000_0000, 32'hFFFF_FFFF);
        load_entry(2, $urandom, 32'h0000_0000);
        load_entry(MAX_PATTERN_WORDS - 1, $urandom, $urandom);

        // A match at offset one, then a word after the match that ends the region quietly.
        scan_word(32'h0000_0000, 1'b0);
        scan_word(signature[0], 1'b0);
        scan_word(signature[1], 1'b0);
        scan_word($urandom, 1'b0);
        scan_word($urandom, 1'b1);
        // A region shorter than the signature.
        scan_word(signature[0], 1'b0);
        scan_word(signature[1], 1'b1);
        // A near miss on the word under a full mask, ending on an all-ones word.
        scan_word(signature[0], 1'b0);
        scan_word(signature[1] ^ 32'h1, 1'b0);
        scan_word($urandom, 1'b0);
        scan_word(32'hFFFF_FFFF, 1'b1);
        // A match at the last start that fits, found on the closing word itself.
        scan_word($urandom, 1'b0);
        scan_word(signature[0], 1'b0);
        scan_word(signature[1], 1'b0);
        scan_word($urandom, 1'b1);
        // A restart in the middle of a signature leaves too few words behind it.
        scan_word(signature[0], 1'b0);
        restart_scan();
        scan_word(signature[0], 1'b0);
        scan_word(signature[1], 1'b1);
        // The unused opcode must leave everything alone.
        send_request(random_request(OP_IGNORED));

        // Random phases. Each one settles, picks a new length and base (the extremes
        // and out-of-range lengths among them), sometimes reloads the signature and then
        // runs a batch of regions. The first phase always loads all sixteen entries so
        // that no compare ever looks at an entry that was never written.
        first_phase = 1'b1;
        while (requests_sent < REQUEST_TARGET)
        begin
            settle();
            idle_odds = (requests_sent >= CALM_FROM) ? 0 : $urandom_range(0, 3);

            case ($urandom_range(0, 9))
                0:       length_choice = 0;
                1:       length_choice = 1;
                2:       length_choice = MAX_PATTERN_WORDS;
                3:       length_choice = $urandom_range(MAX_PATTERN_WORDS + 1, 31);
                default: length_choice = $urandom_range(1, 8);
            endcase
            length_value = 32'(length_choice);
            if ($urandom_range(0, 3) == 0)
                length_value = length_value | ($urandom & ~32'h1F);
            case ($urandom_range(0, 5))
                0:       base_value = 32'h0000_0000;
                1:       base_value = 32'hFFFF_FFFF;
                2:       base_value = 32'hFFFF_FFFC;
                default: base_value = $urandom;
            endcase
            if ($urandom_range(0, 1) == 0)
            begin
                put_register(CFG_PATTERN_LENGTH, length_value);
                put_register(CFG_SCAN_BASE, base_value);
            end
            else
            begin
                put_register(CFG_SCAN_BASE, base_value);
                put_register(CFG_PATTERN_LENGTH, length_value);
            end
            if ($urandom_range(0, 3) == 0)
                put_register(CFG_SPARE, $urandom);
            cfg_ch.valid <= 1'b0;

            // The block clamps the length into 1..16; the stimulus plans with the same.
            words_used = (length_choice == 0) ? 1
                       : (length_choice > MAX_PATTERN_WORDS) ? MAX_PATTERN_WORDS
                       : length_choice;

            if (first_phase || $urandom_range(0, 3) == 0)
                load_signature();
            first_phase = 1'b0;
            if ($urandom_range(0, 1) == 0)
                restart_scan();

            regions = $urandom_range(3, 10);
            repeat (regions)
            begin
                run_region(words_used);
                if (requests_sent >= CALM_FROM)
                    idle_odds = 0;
            end
        end

        idle_odds = 0;
        settle();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
